### design/page_frame_allocator_refcount_unit_assert.svh
// Assertion macros for the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("page frame allocator assertion failed");
`define PFA_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("page frame allocator assertion failed");
`else
`define PFA_ASSERT(label, clk, rst, prop)
`define PFA_ASSERT_NR(label, clk, prop)
`endif
`endif

### design/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   localparam int NUM_PAGES_DEF  = 16384;
   localparam int PAGE_SHIFT_DEF = 12;
   localparam int COUNT_BITS_DEF = 16;

   localparam int ADDR_W     = 32;
   localparam int OP_W       = 2;
   localparam int ST_W       = 3;
   localparam int REF_W      = 16;
   localparam int START_W    = 14;
   localparam int WORD_BITS  = 32;
   localparam int OFF_W      = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_NO_FRAME  = 3'd1;
   localparam logic [ST_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [ST_W-1:0] ST_NOT_ALLOC = 3'd3;
   localparam logic [ST_W-1:0] ST_FLOOR     = 3'd4;
   localparam logic [ST_W-1:0] ST_COUNT     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_START = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_FLOOR  = 8'd1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] byte_addr;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [ADDR_W-1:0] frame_addr;
      logic              released;
      logic [REF_W-1:0]  ref_count;
      logic              in_use;
   } rsp_type;

endpackage

`default_nettype wire

### design/page_frame_allocator_refcount_unit.sv
// Free, mark and query: taken in S_IDLE, result registered from S_UPDATE once the output is free; no new
// request is taken before that result. Alloc: scans one 32-bit used-bit word per cycle from the start
// page's word up to the last word, then registers the result from S_UPDATE.
// Reset: synchronous; afterwards a clearing pass writes every entry of both stores, one page a
// cycle, with req_stall high. csr writes are taken always.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_allocator_refcount_unit_assert.svh"

module page_frame_allocator_refcount_unit #(
   parameter int NUM_PAGES  = pfa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF,
   parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pfa_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pfa_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pfa_pkg::*;

   localparam int PAGE_W    = $clog2(NUM_PAGES);
   localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int ITER_W    = WORD_W + 1;
   localparam int PN_W      = ADDR_W - PAGE_SHIFT;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [PAGE_W-1:0]     clr_ff, clr_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic                  early_ff, early_in;
   logic [ST_W-1:0]       early_st_ff, early_st_in;
   logic [ITER_W-1:0]     iss_ff, iss_in;
   logic                  pend_ff, pend_in;
   logic [WORD_W-1:0]     pend_word_ff, pend_word_in;
   logic [WORD_BITS-1:0]  word_ff, word_in;
   logic [START_W-1:0]    start_ff, start_in;
   logic [ADDR_W-1:0]     floor_ff, floor_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [WORD_BITS-1:0]  used_mem [NUM_WORDS];
   logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
   logic [WORD_BITS-1:0]  used_q_ff;
   logic [COUNT_BITS-1:0] cnt_q_ff;

   logic                  used_re, used_we, cnt_re, cnt_we;
   logic [WORD_W-1:0]     used_ra, used_wa;
   logic [WORD_BITS-1:0]  used_wd;
   logic [PAGE_W-1:0]     cnt_ra, cnt_wa;
   logic [COUNT_BITS-1:0] cnt_wd;

   logic [PN_W-1:0]       req_pn;
   logic                  req_in_range;
   logic [PAGE_W-1:0]     req_page;
   logic [WORD_W-1:0]     req_word;
   logic                  start_ok;
   logic [WORD_W-1:0]     start_word;
   logic                  ff_found;
   logic [OFF_W-1:0]      ff_off;
   logic [PAGE_W-1:0]     found_page;
   logic [ADDR_W-1:0]     page_wide;
   logic [OFF_W-1:0]      bit_off;
   logic [WORD_W-1:0]     page_word;
   logic                  out_free;

   rsp_type               upd_rsp;
   logic                  upd_used_we, upd_cnt_we;
   logic [WORD_BITS-1:0]  upd_used_wd;
   logic [COUNT_BITS-1:0] upd_cnt_wd;

   assign req_pn       = req_data.byte_addr[ADDR_W-1:PAGE_SHIFT];
   assign req_in_range = ADDR_W'(req_pn) < ADDR_W'(NUM_PAGES);
   assign req_page     = PAGE_W'(req_pn);
   assign req_word     = WORD_W'(ADDR_W'(req_page) >> OFF_W);
   assign start_ok     = ADDR_W'(start_ff) < ADDR_W'(NUM_PAGES);
   assign start_word   = WORD_W'(start_ff >> OFF_W);
   assign found_page   = PAGE_W'((ADDR_W'(pend_word_ff) << OFF_W) | ADDR_W'(ff_off));
   assign page_wide    = ADDR_W'(page_ff);
   assign bit_off      = page_wide[OFF_W-1:0];
   assign page_word    = WORD_W'(page_wide >> OFF_W);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   pfa_first_free #(
      .NUM_PAGES (NUM_PAGES),
      .WORD_W    (WORD_W)
   ) u_first_free (
      .word      (used_q_ff),
      .word_idx  (pend_word_ff),
      .first     (pend_word_ff == start_word),
      .start_off (start_ff[OFF_W-1:0]),
      .found     (ff_found),
      .offset    (ff_off)
   );

   always_comb begin
      logic [WORD_BITS-1:0]  rmw_word;
      logic                  ubit;
      logic [COUNT_BITS-1:0] cnt_inc;
      logic [COUNT_BITS-1:0] cnt_dec;
      logic [WORD_BITS-1:0]  bit_mask;
      rmw_word    = (op_ff == OP_ALLOC) ? word_ff : used_q_ff;
      ubit        = rmw_word[bit_off];
      cnt_inc     = cnt_q_ff + COUNT_BITS'(1);
      cnt_dec     = cnt_q_ff - COUNT_BITS'(1);
      bit_mask    = WORD_BITS'(1) << bit_off;
      upd_rsp     = '0;
      upd_used_we = 1'b0;
      upd_used_wd = rmw_word;
      upd_cnt_we  = 1'b0;
      upd_cnt_wd  = cnt_q_ff;
      if (early_ff) begin
         upd_rsp.status = early_st_ff;
      end else begin
         case (op_ff)
            OP_ALLOC, OP_MARK: begin
               if (&cnt_q_ff) begin
                  upd_rsp.status    = ST_COUNT;
                  upd_rsp.ref_count = REF_W'(cnt_q_ff);
                  upd_rsp.in_use    = ubit;
               end else begin
                  upd_cnt_we        = 1'b1;
                  upd_cnt_wd        = cnt_inc;
                  upd_used_we       = 1'b1;
                  upd_used_wd       = rmw_word | bit_mask;
                  upd_rsp.status    = ST_OK;
                  upd_rsp.ref_count = REF_W'(cnt_inc);
                  upd_rsp.in_use    = 1'b1;
                  if (op_ff == OP_ALLOC) begin
                     upd_rsp.frame_addr = page_wide << PAGE_SHIFT;
                  end
               end
            end
            OP_FREE: begin
               upd_rsp.ref_count = REF_W'(cnt_q_ff);
               upd_rsp.in_use    = ubit;
               if (cnt_q_ff == '0) begin
                  upd_rsp.status = ST_COUNT;
               end else if (cnt_q_ff != COUNT_BITS'(1)) begin
                  upd_cnt_we        = 1'b1;
                  upd_cnt_wd        = cnt_dec;
                  upd_rsp.status    = ST_OK;
                  upd_rsp.ref_count = REF_W'(cnt_dec);
               end else if (addr_ff < floor_ff) begin
                  upd_rsp.status = ST_FLOOR;
               end else if (!ubit) begin
                  upd_rsp.status = ST_NOT_ALLOC;
               end else begin
                  upd_cnt_we        = 1'b1;
                  upd_cnt_wd        = '0;
                  upd_used_we       = 1'b1;
                  upd_used_wd       = rmw_word & ~bit_mask;
                  upd_rsp.status    = ST_OK;
                  upd_rsp.released  = 1'b1;
                  upd_rsp.ref_count = '0;
                  upd_rsp.in_use    = 1'b0;
               end
            end
            default: begin
               upd_rsp.status    = ST_OK;
               upd_rsp.ref_count = REF_W'(cnt_q_ff);
               upd_rsp.in_use    = ubit;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      page_in      = page_ff;
      early_in     = early_ff;
      early_st_in  = early_st_ff;
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      pend_word_in = pend_word_ff;
      word_in      = word_ff;
      start_in     = start_ff;
      floor_in     = floor_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      used_re      = 1'b0;
      used_ra      = req_word;
      used_we      = 1'b0;
      used_wa      = page_word;
      used_wd      = upd_used_wd;
      cnt_re       = 1'b0;
      cnt_ra       = req_page;
      cnt_we       = 1'b0;
      cnt_wa       = page_ff;
      cnt_wd       = upd_cnt_wd;

      if (csr_valid) begin
         case (csr_index)
            CSR_ALLOC_START: start_in = csr_wdata[START_W-1:0];
            CSR_FREE_FLOOR:  floor_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            used_we = 1'b1;
            used_wa = WORD_W'(ADDR_W'(clr_ff) >> OFF_W);
            used_wd = '0;
            cnt_we  = 1'b1;
            cnt_wa  = clr_ff;
            cnt_wd  = '0;
            if (clr_ff == PAGE_W'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + PAGE_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               addr_in  = req_data.byte_addr;
               early_in = 1'b0;
               pend_in  = 1'b0;
               state_in = S_UPDATE;
               if (req_data.op == OP_ALLOC) begin
                  if (start_ok) begin
                     iss_in   = ITER_W'(start_word);
                     state_in = S_SCAN;
                  end else begin
                     early_in    = 1'b1;
                     early_st_in = ST_NO_FRAME;
                  end
               end else if (!req_in_range) begin
                  early_in    = 1'b1;
                  early_st_in = ST_RANGE;
               end else begin
                  page_in = req_page;
                  used_re = 1'b1;
                  cnt_re  = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && ff_found) begin
               page_in  = found_page;
               word_in  = used_q_ff;
               cnt_re   = 1'b1;
               cnt_ra   = found_page;
               pend_in  = 1'b0;
               state_in = S_UPDATE;
            end else if (pend_ff && (pend_word_ff == WORD_W'(NUM_WORDS - 1))) begin
               early_in    = 1'b1;
               early_st_in = ST_NO_FRAME;
               pend_in     = 1'b0;
               state_in    = S_UPDATE;
            end else if (iss_ff < ITER_W'(NUM_WORDS)) begin
               used_re      = 1'b1;
               used_ra      = WORD_W'(iss_ff);
               pend_in      = 1'b1;
               pend_word_in = WORD_W'(iss_ff);
               iss_in       = iss_ff + ITER_W'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = upd_rsp;
               used_we      = upd_used_we;
               cnt_we       = upd_cnt_we;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         floor_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         floor_ff     <= floor_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      page_ff      <= page_in;
      early_ff     <= early_in;
      early_st_ff  <= early_st_in;
      iss_ff       <= iss_in;
      pend_word_ff <= pend_word_in;
      word_ff      <= word_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (used_re) begin
         used_q_ff <= used_mem[used_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (cnt_re) begin
         cnt_q_ff <= cnt_mem[cnt_ra];
      end
   end

   `PFA_ASSERT_NR(a_reset_clears, clock, reset |=> (state_ff == S_CLEAR))
   `PFA_ASSERT(a_clear_quiet, clock, reset, (state_ff == S_CLEAR) |-> !rsp_valid_ff)
   `PFA_ASSERT(a_pend_in_scan, clock, reset, pend_ff |-> (state_ff == S_SCAN))
   `PFA_ASSERT(a_upd_page, clock, reset, (state_ff == S_UPDATE && !early_ff) |-> (ADDR_W'(page_ff) < ADDR_W'(NUM_PAGES)))
   `PFA_ASSERT(a_release_clean, clock, reset, (rsp_valid_ff && rsp_ff.released) |-> (rsp_ff.status == ST_OK && rsp_ff.ref_count == '0 && !rsp_ff.in_use))

endmodule

`default_nettype wire

### design/pfa_first_free.sv
`timescale 1ns / 1ps
`default_nettype none

module pfa_first_free #(
   parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
   parameter int WORD_W    = 9
) (
   input  logic [pfa_pkg::WORD_BITS-1:0] word,
   input  logic [WORD_W-1:0]             word_idx,
   input  logic                          first,
   input  logic [pfa_pkg::OFF_W-1:0]     start_off,
   output logic                          found,
   output logic [pfa_pkg::OFF_W-1:0]     offset
);
   import pfa_pkg::*;

   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] lowest;

   always_comb begin
      logic [ADDR_W-1:0] page;
      for (int i = 0; i < WORD_BITS; i++) begin
         page = (ADDR_W'(word_idx) << OFF_W) | ADDR_W'(i);
         cand[i] = !word[i] && (page < ADDR_W'(NUM_PAGES))
                   && !(first && (OFF_W'(i) < start_off));
      end
   end

   // isolate lowest free bit
   assign lowest = cand & (~cand + WORD_BITS'(1));
   assign found  = |cand;

   always_comb begin
      offset = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) begin
            offset = offset | OFF_W'(i);
         end
      end
   end

endmodule

`default_nettype wire
